FILE: hw/rtl/pacr_pkg.sv
// ----------------------------------------------------------------------------
// pacr_pkg
// Shared types and constants for the polygon area / coverage ratio core.
// ----------------------------------------------------------------------------
package pacr_pkg;

   localparam int COORD_BITS         = 24;
   localparam int COVERAGE_FRAC_BITS = 16;
   localparam int COVERED_BITS       = 48;
   localparam int AREA_BITS          = 64;
   localparam int COVERAGE_BITS      = 32;
   localparam int PROD_BITS          = 2 * COORD_BITS;
   localparam int DIV_BITS           = COVERED_BITS + COVERAGE_FRAC_BITS;

   // ring kinds
   localparam logic [1:0] RING_FP_EXT   = 2'd0;
   localparam logic [1:0] RING_FP_HOLE  = 2'd1;
   localparam logic [1:0] RING_GND_EXT  = 2'd2;
   localparam logic [1:0] RING_GND_HOLE = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOT_POS = 2'd1;
   localparam logic [1:0] STATUS_SAT     = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_coord;
      logic signed [COORD_BITS-1:0] y_coord;
      logic [1:0]                   ring_kind;
      logic                         ring_end;
      logic                         job_end;
      logic [COVERED_BITS-1:0]      covered_area;
   } req_word_type;

   typedef struct packed {
      logic signed [AREA_BITS-1:0] net_area;
      logic [COVERAGE_BITS-1:0]    coverage;
      logic [1:0]                  status;
   } rsp_word_type;

   // one finished job handed from front to back
   typedef struct packed {
      logic signed [AREA_BITS-1:0] net_area;
      logic [COVERED_BITS-1:0]     covered_area;
   } job_word_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_sts_type;

endpackage

FILE: hw/rtl/polygon_area_coverage_ratio_core.sv
// ----------------------------------------------------------------------------
// polygon_area_coverage_ratio_core
// Shoelace ring areas folded into a net area; per job, coverage ratio Q16.16.
// ----------------------------------------------------------------------------
//  channel   handshake          word
//  input     push / full        req_word  (vertex, ring kind, end marks, area)
//  result    empty / pop        rsp_word  (net area, coverage, status)
//
//  Front: a vertex that opens a ring is latched; a continuing vertex adds
//  one cross product (MUL, ACC); a closing vertex also adds the second cross
//  product, abs and add (MUL, ACC, ABS, AREA); one shared pair of 24x24
//  multipliers and the 64-bit ring-sum adder serve both cross products.
//  Back: the 64-step bit-serial divider, skipped when the net area is not
//  positive. A 2-entry job queue lets front and back stall apart; the result
//  register holds a word while the next job runs. Synchronous reset clears control state and front coords and sums.
// ----------------------------------------------------------------------------
module polygon_area_coverage_ratio_core import pacr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   output logic          full,
   input  req_word_type  req_word,
   output logic          empty,
   input  logic          pop,
   output rsp_word_type  rsp_word
);

   queue_ctl_type q_ctl;
   queue_sts_type q_sts;
   job_word_type  q_wr_word, q_rd_word;
   logic          q_push, q_pop;

   assign q_ctl = '{push: q_push, pop: q_pop};

   pacr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_word (req_word),
      .q_full   (q_sts.full),
      .q_push   (q_push),
      .q_word   (q_wr_word)
   );

   pacr_job_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl     (q_ctl),
      .sts     (q_sts),
      .wr_word (q_wr_word),
      .rd_word (q_rd_word)
   );

   pacr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_sts.empty),
      .q_pop    (q_pop),
      .q_word   (q_rd_word),
      .empty    (empty),
      .pop      (pop),
      .rsp_word (rsp_word)
   );

endmodule

FILE: hw/rtl/pacr_front.sv
// ----------------------------------------------------------------------------
// pacr_front
// Vertex intake: shoelace cross products, ring closing, net area accumulate.
// ----------------------------------------------------------------------------
module pacr_front import pacr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   output logic          full,
   input  req_word_type  req_word,
   input  logic          q_full,
   output logic          q_push,
   output job_word_type  q_word
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_ACC  = 3'd2;
   localparam logic [2:0] S_ABS  = 3'd3;
   localparam logic [2:0] S_AREA = 3'd4;

   logic [2:0]                   state_ff, state_in;
   req_word_type                 cur_ff, cur_in;
   logic signed [COORD_BITS-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                         ring_start_ff, ring_start_in;
   logic                         close_ff, close_in;
   logic [AREA_BITS-1:0]         ring_sum_ff, ring_sum_in;
   logic [AREA_BITS-1:0]         mag_ff, mag_in;
   logic [AREA_BITS-1:0]         area_total_ff, area_total_in;
   logic signed [PROD_BITS-1:0]  prod_p_ff, prod_p_in, prod_q_ff, prod_q_in;

   logic signed [COORD_BITS-1:0] op_ax, op_ay, op_bx, op_by;
   logic [AREA_BITS-1:0]         ext_p, ext_q, area_step, area_next;
   logic                         item_end;

   assign item_end = cur_ff.ring_end | cur_ff.job_end;
   assign full     = (state_ff != S_IDLE);

   always_comb begin
      if (close_ff) begin
         op_ax = cur_ff.x_coord;
         op_ay = cur_ff.y_coord;
         op_bx = first_x_ff;
         op_by = first_y_ff;
      end else begin
         op_ax = prev_x_ff;
         op_ay = prev_y_ff;
         op_bx = cur_ff.x_coord;
         op_by = cur_ff.y_coord;
      end
   end

   assign ext_p     = {{(AREA_BITS-PROD_BITS){prod_p_ff[PROD_BITS-1]}}, prod_p_ff};
   assign ext_q     = {{(AREA_BITS-PROD_BITS){prod_q_ff[PROD_BITS-1]}}, prod_q_ff};
   assign area_step = {1'b0, mag_ff[AREA_BITS-1:1]};

   always_comb begin
      case (cur_ff.ring_kind) inside
         RING_FP_EXT, RING_GND_HOLE: area_next = area_total_ff + area_step;
         default:                    area_next = area_total_ff - area_step;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      ring_start_in = ring_start_ff;
      close_in      = close_ff;
      ring_sum_in   = ring_sum_ff;
      mag_in        = mag_ff;
      area_total_in = area_total_ff;
      prod_p_in     = prod_p_ff;
      prod_q_in     = prod_q_ff;
      q_push        = 1'b0;
      q_word        = '{net_area: area_next, covered_area: cur_ff.covered_area};
      unique case (state_ff)
         S_IDLE: begin
            if (push) begin
               cur_in = req_word;
               if (ring_start_ff) begin
                  first_x_in    = req_word.x_coord;
                  first_y_in    = req_word.y_coord;
                  prev_x_in     = req_word.x_coord;
                  prev_y_in     = req_word.y_coord;
                  ring_sum_in   = '0;
                  ring_start_in = 1'b0;
                  if (req_word.ring_end | req_word.job_end) begin
                     close_in = 1'b1;
                     state_in = S_MUL;
                  end
               end else begin
                  close_in = 1'b0;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            prod_p_in = PROD_BITS'(op_ax) * PROD_BITS'(op_by);
            prod_q_in = PROD_BITS'(op_ay) * PROD_BITS'(op_bx);
            state_in  = S_ACC;
         end
         S_ACC: begin
            ring_sum_in = ring_sum_ff + (ext_p - ext_q);
            if (close_ff) begin
               close_in = 1'b0;
               state_in = S_ABS;
            end else begin
               prev_x_in = cur_ff.x_coord;
               prev_y_in = cur_ff.y_coord;
               if (item_end) begin
                  close_in = 1'b1;
                  state_in = S_MUL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ABS: begin
            mag_in   = ring_sum_ff[AREA_BITS-1] ? (AREA_BITS'(0) - ring_sum_ff) : ring_sum_ff;
            state_in = S_AREA;
         end
         S_AREA: begin
            if (cur_ff.job_end) begin
               if (!q_full) begin
                  q_push        = 1'b1;
                  area_total_in = '0;
                  ring_start_in = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               area_total_in = area_next;
               ring_start_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ring_start_ff <= 1'b1;
         close_ff      <= 1'b0;
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         ring_sum_ff   <= '0;
         area_total_ff <= '0;
      end else begin
         state_ff      <= state_in;
         ring_start_ff <= ring_start_in;
         close_ff      <= close_in;
         first_x_ff    <= first_x_in;
         first_y_ff    <= first_y_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         ring_sum_ff   <= ring_sum_in;
         area_total_ff <= area_total_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      mag_ff    <= mag_in;
      prod_p_ff <= prod_p_in;
      prod_q_ff <= prod_q_in;
   end

endmodule

FILE: hw/rtl/pacr_job_queue.sv
// ----------------------------------------------------------------------------
// pacr_job_queue
// Two-entry queue of finished jobs between front and back.
// ----------------------------------------------------------------------------
module pacr_job_queue import pacr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  queue_ctl_type ctl,
   output queue_sts_type sts,
   input  job_word_type  wr_word,
   output job_word_type  rd_word
);

   job_word_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign sts.full  = (count_ff == 2'd2);
   assign sts.empty = (count_ff == 2'd0);
   assign do_push   = ctl.push & ~sts.full;
   assign do_pop    = ctl.pop & ~sts.empty;
   assign rd_word   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule

FILE: hw/rtl/pacr_back.sv
// ----------------------------------------------------------------------------
// pacr_back
// Per-job coverage: sign check, bit-serial restoring divide, result register.
// ----------------------------------------------------------------------------
module pacr_back import pacr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   output logic          q_pop,
   input  job_word_type  q_word,
   output logic          empty,
   input  logic          pop,
   output rsp_word_type  rsp_word
);

   localparam int CNT_BITS = $clog2(DIV_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_BITS - 1);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_DIV  = 2'd1;
   localparam logic [1:0] B_OUT  = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic signed [AREA_BITS-1:0] net_ff, net_in;
   logic                      not_pos_ff, not_pos_in;
   logic [AREA_BITS-1:0]      rem_ff, rem_in;
   logic [DIV_BITS-1:0]       dvd_ff, dvd_in;
   logic [DIV_BITS-1:0]       quo_ff, quo_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic                      out_valid_ff, out_valid_in;
   rsp_word_type              out_ff, out_in;

   logic [AREA_BITS-1:0]      rem_sh;
   logic                      ge;
   logic                      out_free;
   logic                      sat;
   rsp_word_type              res;

   // rem stays below the divisor (< 2^63), so its top bit is always clear
   assign rem_sh   = {rem_ff[AREA_BITS-2:0], dvd_ff[DIV_BITS-1]};
   assign ge       = (rem_sh >= net_ff);
   assign out_free = ~out_valid_ff | pop;
   assign sat      = |quo_ff[DIV_BITS-1:COVERAGE_BITS];
   assign empty    = ~out_valid_ff;
   assign rsp_word = out_ff;

   always_comb begin
      res.net_area = net_ff;
      if (not_pos_ff) begin
         res.coverage = '0;
         res.status   = STATUS_NOT_POS;
      end else if (sat) begin
         res.coverage = '1;
         res.status   = STATUS_SAT;
      end else begin
         res.coverage = quo_ff[COVERAGE_BITS-1:0];
         res.status   = STATUS_OK;
      end
   end

   always_comb begin
      state_in     = state_ff;
      net_in       = net_ff;
      not_pos_in   = not_pos_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~pop;
      q_pop        = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop      = 1'b1;
               net_in     = q_word.net_area;
               not_pos_in = q_word.net_area[AREA_BITS-1] | (q_word.net_area == '0);
               rem_in     = '0;
               dvd_in     = {q_word.covered_area, {COVERAGE_FRAC_BITS{1'b0}}};
               quo_in     = '0;
               cnt_in     = '0;
               if (q_word.net_area[AREA_BITS-1] | (q_word.net_area == '0)) begin
                  state_in = B_OUT;
               end else begin
                  state_in = B_DIV;
               end
            end
         end
         B_DIV: begin
            rem_in = ge ? (rem_sh - net_ff) : rem_sh;
            quo_in = {quo_ff[DIV_BITS-2:0], ge};
            dvd_in = {dvd_ff[DIV_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (out_free) begin
               out_in       = res;
               out_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      net_ff     <= net_in;
      not_pos_ff <= not_pos_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      quo_ff     <= quo_in;
      out_ff     <= out_in;
   end

endmodule
